### src/kvt_pkg.sv
// Shared types and constants for the linear key-value table.
`timescale 1ns / 1ps

package kvt_pkg;

    localparam int VAL_W     = 32;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 2;
    localparam int ECOUNT_W  = 6;
    localparam int IN_KEY_W  = 32;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd3;

    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic cmp;
        logic live;
        logic load;
        logic shift;
        logic wr_val;
    } cell_ctl_t;

endpackage

### src/key_value_table_linear_top.sv
// Top level of the linear key-value table: stream ports, sequencing and result register.
`timescale 1ns / 1ps

// Usage:
// Each beat on the s_axis channel is one operation: lookup, insert, delete or
// update of the first entry with a matching key. Each operation gives exactly one
// beat on the m_axis channel with found, value, entry count and status.
// Entries live in a row of cells in insertion order. At the accepting edge every
// cell compares its stored key with the beat's key; in the apply state the first
// match is resolved, the row is written (a delete shifts later cells down by one)
// and the result is loaded into the output register.
// An operation passes from the compare register in each cell to the apply state,
// and the block takes no new beat until the apply state of the last one ends.
// s_axis_tready is high in the idle state only, so one operation is in flight.
// A result waiting in the output register does not block the next acceptance;
// when the receiver stalls with a result still held, the following operation
// waits in its apply cycle until the output register is free.
// Reset empties the table (entry count zero) and drops any pending result;
// stored keys and values need no clearing because only counted entries are read.
module key_value_table_linear_top
    import kvt_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int KEY_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // action [1:0], key [33:2], new_value [65:34], zero fill [71:66]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // found [0], value [32:1], entry_count [38:33], status [40:39], zero fill [47:41]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_APPLY = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [ACT_W-1:0]    act_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [VAL_W-1:0]    nv_reg;
    logic                out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    logic                in_fire;
    logic                apply_go;
    logic [ACT_W-1:0]    in_action;
    logic [KEY_BITS-1:0] op_key;
    logic [VAL_W-1:0]    op_val;
    logic                full;

    logic [CAPACITY-1:0][KEY_BITS-1:0] keys;
    logic [CAPACITY-1:0][VAL_W-1:0]    vals;
    logic [CAPACITY-1:0]               hits;
    logic [CAPACITY-1:0]               first_hot;
    logic [CAPACITY-1:0]               upto;
    logic                              any;
    logic [VAL_W-1:0]                  sel_val;

    logic                found;
    logic [VAL_W-1:0]    res_val;
    logic [STAT_W-1:0]   res_stat;

    // The beat's key is compared while idle; the held copy is written on insert.
    assign in_action = s_axis_tdata[1:0];
    assign op_key    = (state_reg == S_IDLE) ? KEY_BITS'(s_axis_tdata[33:2]) : key_reg;
    assign op_val    = nv_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign apply_go      = (state_reg == S_APPLY) && (!out_valid_reg || m_axis_tready);
    assign full          = (count_reg == CNT_W'(CAPACITY));

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            cell_ctl_t           ctl;
            logic [KEY_BITS-1:0] nb_key;
            logic [VAL_W-1:0]    nb_val;

            if (i == CAPACITY - 1)
            begin : g_end
                assign nb_key = '0;
                assign nb_val = '0;
            end
            else
            begin : g_mid
                assign nb_key = keys[i+1];
                assign nb_val = vals[i+1];
            end

            always_comb
            begin
                ctl.cmp    = in_fire;
                ctl.live   = (CNT_W'(i) < count_reg);
                ctl.load   = apply_go && (act_reg == ACT_INSERT) && !full
                             && (count_reg == CNT_W'(i));
                ctl.shift  = apply_go && (act_reg == ACT_DELETE) && upto[i];
                ctl.wr_val = apply_go && (act_reg == ACT_UPDATE) && first_hot[i];
            end

            kvt_cell #(
                .KEY_BITS(KEY_BITS)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl),
                .op_key (op_key),
                .op_val (op_val),
                .nb_key (nb_key),
                .nb_val (nb_val),
                .key    (keys[i]),
                .val    (vals[i]),
                .hit    (hits[i])
            );
        end
    endgenerate

    kvt_first #(
        .CAPACITY(CAPACITY)
    ) u_first (
        .hits      (hits),
        .vals      (vals),
        .first_hot (first_hot),
        .upto      (upto),
        .any       (any),
        .sel_val   (sel_val)
    );

    always_comb
    begin
        found      = 1'b0;
        res_val    = '0;
        res_stat   = ST_DONE;
        count_next = count_reg;
        if (act_reg == ACT_INSERT)
        begin
            if (full)
            begin
                res_stat = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (any)
        begin
            found = 1'b1;
            if (act_reg == ACT_LOOKUP)
            begin
                res_val = sel_val;
            end
            else if (act_reg == ACT_DELETE)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
        else
        begin
            res_stat = ST_ABSENT;
        end
        out_data_next = {7'd0, res_stat, ECOUNT_W'(count_next), res_val, found};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (apply_go)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg <= in_action;
            key_reg <= KEY_BITS'(s_axis_tdata[33:2]);
            nv_reg  <= s_axis_tdata[65:34];
        end
        if (apply_go)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### src/kvt_cell.sv
// One table entry: stored key and value, key compare, and shift from the next entry.
`timescale 1ns / 1ps

module kvt_cell
    import kvt_pkg::*;
#(
    parameter int KEY_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctl_t           ctl,
    input  logic [KEY_BITS-1:0] op_key,
    input  logic [VAL_W-1:0]    op_val,
    input  logic [KEY_BITS-1:0] nb_key,
    input  logic [VAL_W-1:0]    nb_val,
    output logic [KEY_BITS-1:0] key,
    output logic [VAL_W-1:0]    val,
    output logic                hit
);

    logic [KEY_BITS-1:0] key_reg;
    logic [VAL_W-1:0]    val_reg;
    logic                hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg <= op_key;
            val_reg <= op_val;
        end
        else if (ctl.shift)
        begin
            key_reg <= nb_key;
            val_reg <= nb_val;
        end
        else if (ctl.wr_val)
        begin
            val_reg <= op_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.cmp)
        begin
            hit_reg <= ctl.live && (key_reg == op_key);
        end
    end

    assign key = key_reg;
    assign val = val_reg;
    assign hit = hit_reg;

endmodule

### src/kvt_first.sv
// Finds the first matching entry and selects its value.
`timescale 1ns / 1ps

module kvt_first
    import kvt_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic [CAPACITY-1:0]           hits,
    input  logic [CAPACITY-1:0][VAL_W-1:0] vals,
    output logic [CAPACITY-1:0]           first_hot,
    output logic [CAPACITY-1:0]           upto,
    output logic                          any,
    output logic [VAL_W-1:0]              sel_val
);

    logic [CAPACITY-1:0] pre;

    always_comb
    begin
        pre = hits;
        for (int s = 1; s < CAPACITY; s = s * 2)
        begin
            pre = pre | (pre << s);
        end
    end

    assign upto      = pre;
    assign first_hot = hits & ~(pre << 1);
    assign any       = pre[CAPACITY-1];

    always_comb
    begin
        sel_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel_val = sel_val | (vals[i] & {VAL_W{first_hot[i]}});
        end
    end

endmodule
